// ===== sv/dq_pkg.sv =====
// dq_pkg: operation codes, status codes and the control word passed between
// the deque pipeline modules. No dependencies.
package dq_pkg;

	localparam int VALUE_W  = 32;
	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;

	typedef logic [MODE_W-1:0]   mode_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam mode_t MODE_PUSH_BACK  = 3'd0;
	localparam mode_t MODE_PUSH_FRONT = 3'd1;
	localparam mode_t MODE_POP_BACK   = 3'd2;
	localparam mode_t MODE_POP_FRONT  = 3'd3;
	localparam mode_t MODE_CLEAR      = 3'd4;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	// per-operation flags carried alongside the memory read
	typedef struct packed {
		logic    pop_ok;     // popped slot read is valid
		logic    front_ok;   // queue not empty after the step
		logic    fwd_front;  // new front is the slot written by this operation
		status_t status;
	} dq_ctl_t;

endpackage

// ===== sv/double_ended_queue_top.sv =====
// double_ended_queue_top: bounded deque of signed words in a circular slot
// memory. Depends on dq_pkg, dq_ctrl, dq_store and dq_out.
//
// Usage: each input transfer carries one operation, mode in s_tuser (push
// back, push front, pop back, pop front, clear) and the element in s_tdata.
// Every operation gives exactly one result transfer on the m_ side: popped
// element, front element after the step, occupancy, empty flag, and the
// status in m_tuser (ok, pop on empty, push dropped when full).
// The result passes the held-operation register and then the output register
// before m_tvalid rises; one operation is taken every cycle while s_tready
// is high, set by the single write port and the two read ports
// of the slot memory, whose read data is forwarded when an operation reads
// the slot it writes.
// Reset clears the front index, the count and all valid flags; slot contents
// are not cleared and data read from unoccupied slots never reaches the output.
// When the receiver stalls, one result waits in the output register and one
// operation waits behind it; s_tready then drops until m_tready returns.
module double_ended_queue_top #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W     = $clog2(DEPTH + 1),
	localparam int OUT_W     = ((2 * 32 + CNT_W + 1 + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [dq_pkg::VALUE_W-1:0]  s_tdata,  // value
	input  logic [dq_pkg::MODE_W-1:0]   s_tuser,  // mode
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// popped_value, front_value, occupancy, empty_flag, zero pad
	output logic [OUT_W-1:0]            m_tdata,
	output logic [dq_pkg::STATUS_W-1:0] m_tuser   // status
);

	import dq_pkg::*;

	localparam int PAD_W = OUT_W - 2 * VALUE_W - CNT_W - 1;

	logic                  accept;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         rd_pop_addr;
	logic [AW-1:0]         rd_front_addr;
	dq_ctl_t               ctl;
	logic [CNT_W-1:0]      count_next;
	logic signed [63:0]    in_ext;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [DATA_WIDTH-1:0] rd_pop_q;
	logic [DATA_WIDTH-1:0] rd_front_q;
	logic [VALUE_W-1:0]    popped_value;
	logic [VALUE_W-1:0]    front_value;
	logic [CNT_W-1:0]      occupancy;
	logic                  empty_flag;
	status_t               status;

	assign accept  = s_tvalid && s_tready;
	assign in_ext  = 64'(signed'(s_tdata));
	assign wr_data = in_ext[DATA_WIDTH-1:0];

	dq_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.mode          (mode_t'(s_tuser)),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.rd_pop_addr   (rd_pop_addr),
		.rd_front_addr (rd_front_addr),
		.ctl           (ctl),
		.count_next    (count_next)
	);

	dq_store #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.AW         (AW)
	) u_store (
		.clk           (clk),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_en         (accept),
		.rd_pop_addr   (rd_pop_addr),
		.rd_front_addr (rd_front_addr),
		.rd_pop_q      (rd_pop_q),
		.rd_front_q    (rd_front_q)
	);

	dq_out #(
		.DATA_WIDTH (DATA_WIDTH),
		.CNT_W      (CNT_W)
	) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.ctl          (ctl),
		.count_next   (count_next),
		.wr_data      (wr_data),
		.rd_pop_q     (rd_pop_q),
		.rd_front_q   (rd_front_q),
		.in_ready     (s_tready),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.popped_value (popped_value),
		.front_value  (front_value),
		.occupancy    (occupancy),
		.empty_flag   (empty_flag),
		.status       (status)
	);

	assign m_tdata = {{PAD_W{1'b0}}, empty_flag, occupancy, front_value, popped_value};
	assign m_tuser = status;

endmodule

// ===== sv/dq_store.sv =====
// dq_store: slot memory, one write port and two registered read ports.
// Depends on nothing; widths come from the parameters.
module dq_store #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	parameter int AW         = 4
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [DATA_WIDTH-1:0] wr_data,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_pop_addr,
	input  logic [AW-1:0]         rd_front_addr,
	output logic [DATA_WIDTH-1:0] rd_pop_q,
	output logic [DATA_WIDTH-1:0] rd_front_q
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read-before-write: a same-cycle write is forwarded downstream
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_pop_q   <= mem[rd_pop_addr];
			rd_front_q <= mem[rd_front_addr];
		end
	end

endmodule

// ===== sv/dq_ctrl.sv =====
// dq_ctrl: front index and element count, address generation and status
// for each accepted operation. Depends on dq_pkg.
module dq_ctrl #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int CNT_W = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  dq_pkg::mode_t      mode,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output logic [AW-1:0]      rd_pop_addr,
	output logic [AW-1:0]      rd_front_addr,
	output dq_pkg::dq_ctl_t    ctl,
	output logic [CNT_W-1:0]   count_next
);

	import dq_pkg::*;

	logic [AW-1:0]    front_q;
	logic [CNT_W-1:0] count_q;
	logic [AW-1:0]    front_next;
	logic             full;
	logic             empty;
	logic [CNT_W:0]   sum;
	logic [CNT_W:0]   sum_m1;
	logic [CNT_W:0]   depth_w;
	logic [AW-1:0]    pos_back;
	logic [AW-1:0]    pos_last;
	logic [AW-1:0]    front_dec;
	logic [AW-1:0]    front_inc;
	logic             do_write;
	status_t          status;
	logic             pop_ok;

	assign depth_w = (CNT_W+1)'(DEPTH);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign sum     = (CNT_W+1)'(front_q) + (CNT_W+1)'(count_q);
	assign sum_m1  = sum - 1'b1;

	// sums stay below twice the depth, so one subtract wraps them
	assign pos_back  = (sum >= depth_w) ? AW'(sum - depth_w) : AW'(sum);
	assign pos_last  = (sum_m1 >= depth_w) ? AW'(sum_m1 - depth_w) : AW'(sum_m1);
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;

	always_comb begin
		do_write    = 1'b0;
		wr_addr     = pos_back;
		rd_pop_addr = front_q;
		front_next  = front_q;
		count_next  = count_q;
		status      = ST_OK;
		pop_ok      = 1'b0;
		case (mode)
			MODE_PUSH_BACK: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					do_write   = 1'b1;
					count_next = count_q + 1'b1;
				end
			end
			MODE_PUSH_FRONT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					do_write   = 1'b1;
					wr_addr    = front_dec;
					front_next = front_dec;
					count_next = count_q + 1'b1;
				end
			end
			MODE_POP_BACK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					pop_ok      = 1'b1;
					rd_pop_addr = pos_last;
					count_next  = count_q - 1'b1;
				end
			end
			MODE_POP_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					pop_ok     = 1'b1;
					front_next = front_inc;
					count_next = count_q - 1'b1;
				end
			end
			MODE_CLEAR: begin
				front_next = '0;
				count_next = '0;
			end
			default: begin
			end
		endcase
	end

	assign wr_en         = accept && do_write;
	assign rd_front_addr = front_next;
	assign ctl.pop_ok    = pop_ok;
	assign ctl.front_ok  = (count_next != '0);
	assign ctl.fwd_front = do_write && (wr_addr == front_next);
	assign ctl.status    = status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_next;
			count_q <= count_next;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(DEPTH))
		else $error("element count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n) (CNT_W+1)'(front_q) < depth_w)
		else $error("front index beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && full && (mode == MODE_PUSH_BACK || mode == MODE_PUSH_FRONT) |=>
		$stable(count_q) && $stable(front_q))
		else $error("push on full queue changed state");
`endif

endmodule

// ===== sv/dq_out.sv =====
// dq_out: holds an operation while its slot reads complete, forwards a
// same-operation write and drives the result register. Depends on dq_pkg.
module dq_out #(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  dq_pkg::dq_ctl_t             ctl,
	input  logic [CNT_W-1:0]            count_next,
	input  logic [DATA_WIDTH-1:0]       wr_data,
	input  logic [DATA_WIDTH-1:0]       rd_pop_q,
	input  logic [DATA_WIDTH-1:0]       rd_front_q,
	output logic                        in_ready,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [dq_pkg::VALUE_W-1:0]  popped_value,
	output logic [dq_pkg::VALUE_W-1:0]  front_value,
	output logic [CNT_W-1:0]            occupancy,
	output logic                        empty_flag,
	output dq_pkg::status_t             status
);

	import dq_pkg::*;

	logic                  v_s1;
	dq_ctl_t               ctl_s1;
	logic [CNT_W-1:0]      cnt_s1;
	logic [DATA_WIDTH-1:0] wdata_s1;

	logic                  valid_q;
	logic [VALUE_W-1:0]    popped_q;
	logic [VALUE_W-1:0]    front_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  empty_q;
	status_t               status_q;

	logic                  out_free;
	logic                  adv;
	logic [DATA_WIDTH-1:0] front_raw;
	logic signed [63:0]    pop_ext;
	logic signed [63:0]    front_ext;

	assign out_free = !valid_q || out_ready;
	assign adv      = v_s1 && out_free;
	assign in_ready = !v_s1 || out_free;

	assign front_raw = ctl_s1.fwd_front ? wdata_s1 : rd_front_q;
	assign pop_ext   = 64'(signed'(rd_pop_q));
	assign front_ext = 64'(signed'(front_raw));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= accept;
			end
			if (out_free) begin
				valid_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1   <= ctl;
			cnt_s1   <= count_next;
			wdata_s1 <= wr_data;
		end
		if (adv) begin
			popped_q <= ctl_s1.pop_ok ? pop_ext[VALUE_W-1:0] : '0;
			front_q  <= ctl_s1.front_ok ? front_ext[VALUE_W-1:0] : '0;
			cnt_q    <= cnt_s1;
			empty_q  <= !ctl_s1.front_ok;
			status_q <= ctl_s1.status;
		end
	end

	assign out_valid    = valid_q;
	assign popped_value = popped_q;
	assign front_value  = front_q;
	assign occupancy    = cnt_q;
	assign empty_flag   = empty_q;
	assign status       = status_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (empty_q == (cnt_q == '0)))
		else $error("empty flag disagrees with occupancy");
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && ctl_s1.pop_ok |-> ctl_s1.status == ST_OK)
		else $error("pop taken with a fault status");
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !out_free |=> v_s1 && $stable(cnt_s1))
		else $error("held operation lost while output stalled");
`endif

endmodule

// ===== dv/tb.sv =====
// tb: self-checking bench for double_ended_queue_top, driving operations on the
// s_ stream and checking every m_ transfer against a local deque predictor.
// Depends on dq_pkg and the double_ended_queue_top RTL.
module tb;
	import dq_pkg::*;

	localparam int DEPTH       = 16;
	localparam int RES_W       = ((2 * 32 + 5 + 1 + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_WAIT  = 8;

	typedef struct packed {
		logic [31:0] popped;
		logic [31:0] front;
		logic [4:0]  occupancy;
		logic        empty;
		status_t     status;
	} deque_result_t;

	typedef enum {RX_STEADY, RX_LIGHT, RX_HEAVY} rx_style_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [VALUE_W-1:0]  s_tdata  = '0;
	logic [MODE_W-1:0]   s_tuser  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [RES_W-1:0]    m_tdata;
	logic [STATUS_W-1:0] m_tuser;

	// predictor state
	logic [31:0] slot_mem [DEPTH];
	logic [3:0]  head_idx   = '0;
	logic [4:0]  fill_count = '0;

	deque_result_t results_due[$];
	int          mismatch_count = 0;
	int          result_count   = 0;
	int unsigned cycle_count    = 0;

	// sender burst control
	int burst_left = 0;
	bit gaps_on    = 1'b0;

	// receiver stall control
	rx_style_t   rx_style     = RX_STEADY;
	logic [15:0] rx_pattern   = '1;
	logic [3:0]  rx_phase     = '0;
	int          hold_left    = 0;
	int          hold_request = 0;

	double_ended_queue_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	// applies one operation to the local deque and returns the result it should give
	function automatic deque_result_t apply_deque_op(mode_t op, logic [31:0] val);
		deque_result_t r;
		logic [3:0]    pos;
		r = '0;
		case (op)
		MODE_PUSH_BACK: begin
			if (fill_count == DEPTH) begin
				r.status = ST_FULL;
			end else begin
				pos = head_idx + fill_count[3:0];
				slot_mem[pos] = val;
				fill_count++;
			end
		end
		MODE_PUSH_FRONT: begin
			if (fill_count == DEPTH) begin
				r.status = ST_FULL;
			end else begin
				head_idx = head_idx - 4'd1;
				slot_mem[head_idx] = val;
				fill_count++;
			end
		end
		MODE_POP_BACK: begin
			if (fill_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				// count of sixteen wraps to zero here, so minus one lands on the last slot
				pos = head_idx + fill_count[3:0] - 4'd1;
				r.popped = slot_mem[pos];
				fill_count--;
			end
		end
		MODE_POP_FRONT: begin
			if (fill_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.popped = slot_mem[head_idx];
				head_idx++;
				fill_count--;
			end
		end
		MODE_CLEAR: begin
			fill_count = '0;
			head_idx   = '0;
		end
		default: begin
		end
		endcase
		r.front     = (fill_count != 0) ? slot_mem[head_idx] : '0;
		r.occupancy = fill_count;
		r.empty     = (fill_count == 0);
		return r;
	endfunction

	task automatic note_failure(input string msg);
		$display("tb: mismatch: %s", msg);
		mismatch_count++;
	endtask

	// offers one operation, called and returning at a falling edge
	task automatic send_op(input mode_t op, input logic [31:0] val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= val;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
		0:       return 32'h8000_0000;
		1:       return 32'h7fff_ffff;
		2:       return 32'h0000_0000;
		3:       return 32'hffff_ffff;
		default: return $urandom;
		endcase
	endfunction

	function automatic mode_t pick_mode(input int push_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			return MODE_CLEAR;
		if (roll < 5)
			return mode_t'($urandom_range(5, 7));
		if ($urandom_range(0, 99) < push_pct)
			return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
		return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
	endfunction

	// receiver: stall pattern reloaded each time the four-bit phase wraps, plus optional long hold-off
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (rx_phase == 0) begin
			case (rx_style)
			RX_STEADY: rx_pattern = '1;
			RX_LIGHT:  rx_pattern = 16'($urandom | $urandom);
			default:   rx_pattern = 16'($urandom & $urandom);
			endcase
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= rx_pattern[rx_phase];
		end
		rx_phase++;
	end

	// result check first, then prediction for any input transfer on the same edge
	always @(posedge clk) begin
		deque_result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end else if (arst_n) begin
			if (m_tvalid && m_tready) begin
				result_count++;
				if (results_due.size() == 0) begin
					note_failure($sformatf("result %0d arrived with nothing outstanding",
						result_count));
				end else begin
					want = results_due[0];
					results_due.delete(0);
					if (m_tdata[31:0] !== want.popped)
						note_failure($sformatf("result %0d popped_value %h, want %h",
							result_count, m_tdata[31:0], want.popped));
					if (m_tdata[63:32] !== want.front)
						note_failure($sformatf("result %0d front_value %h, want %h",
							result_count, m_tdata[63:32], want.front));
					if (m_tdata[68:64] !== want.occupancy)
						note_failure($sformatf("result %0d occupancy %0d, want %0d",
							result_count, m_tdata[68:64], want.occupancy));
					if (m_tdata[69] !== want.empty)
						note_failure($sformatf("result %0d empty_flag %b, want %b",
							result_count, m_tdata[69], want.empty));
					if (m_tdata[RES_W-1:70] !== '0)
						note_failure($sformatf("result %0d pad bits %h not zero",
							result_count, m_tdata[RES_W-1:70]));
					if (m_tuser !== want.status)
						note_failure($sformatf("result %0d status %0d, want %0d",
							result_count, m_tuser, want.status));
				end
			end
			if (s_tvalid && s_tready)
				results_due.insert(results_due.size(), apply_deque_op(s_tuser, s_tdata));
		end
	end

	// empty pops, unused modes, extreme values, fill to full, pushes on full, clear
	task automatic test_directed();
		mode_t unused_op;
		send_op(MODE_POP_BACK, 32'h1234_5678);
		send_op(MODE_POP_FRONT, 32'hffff_ffff);
		for (int m = 5; m <= 7; m++) begin
			unused_op = mode_t'(m);
			send_op(unused_op, 32'hdead_beef);
		end
		send_op(MODE_PUSH_BACK, 32'h7fff_ffff);
		send_op(MODE_PUSH_FRONT, 32'h8000_0000);
		send_op(MODE_POP_BACK, 32'h0);
		send_op(MODE_POP_FRONT, 32'h0);
		// alternate ends so the front index wraps while filling
		for (int i = 0; i < DEPTH; i++) begin
			case (i)
			0:       send_op(MODE_PUSH_FRONT, 32'h0000_0000);
			1:       send_op(MODE_PUSH_BACK, 32'hffff_ffff);
			2:       send_op(MODE_PUSH_FRONT, 32'h7fff_ffff);
			3:       send_op(MODE_PUSH_BACK, 32'h8000_0000);
			default: send_op((i % 2) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, $urandom);
			endcase
		end
		send_op(MODE_PUSH_BACK, 32'h5555_5555);
		send_op(MODE_PUSH_FRONT, 32'haaaa_aaaa);
		send_op(MODE_CLEAR, 32'h0);
	endtask

	// long receiver hold-off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		gaps_on      = 1'b0;
		rx_style     = RX_STEADY;
		hold_request = 80;
		for (int i = 0; i < 40; i++)
			send_op(pick_mode(60), pick_value());
	endtask

	// segments cycle through push-heavy, pop-heavy and balanced mixes so occupancy swings between empty and full
	task automatic test_random_mix();
		int push_pct;
		for (int seg = 0; seg < 30; seg++) begin
			if (seg == 0) begin
				gaps_on  = 1'b0;
				rx_style = RX_STEADY;
			end else begin
				gaps_on  = $urandom_range(0, 3) != 0;
				rx_style = rx_style_t'($urandom_range(0, 2));
			end
			case (seg % 3)
			0:       push_pct = $urandom_range(65, 95);
			1:       push_pct = $urandom_range(5, 35);
			default: push_pct = $urandom_range(40, 60);
			endcase
			for (int i = 0; i < 63; i++)
				send_op(pick_mode(push_pct), pick_value());
		end
	endtask

	task automatic finish_run();
		s_tvalid <= 1'b0;
		rx_style = RX_STEADY;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (results_due.size() != 0)
			note_failure($sformatf("%0d results never arrived", results_due.size()));
		if (mismatch_count == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		test_random_mix();
		finish_run();
	end

endmodule
